// ===== hw/rtl/ecd_pkg.sv =====
// Shared types, constants, microcode and helper functions for the calendar date converter.
`default_nettype none

package ecd_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_EPOCH_YEAR    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_EPOCH_WEEKDAY = 1'b1;
  localparam int unsigned CFG_DATA_W = 12;

  // Reset values of the configuration registers.
  localparam logic [11:0] EPOCH_YEAR_RST    = 12'd2000;
  localparam logic [2:0]  EPOCH_WEEKDAY_RST = 3'd6;

  // Carry limits of the time of day and of the year within its century.
  localparam logic [6:0]  SEC_LIMIT  = 7'd60;
  localparam logic [7:0]  MIN_LIMIT  = 8'd60;
  localparam logic [7:0]  HR_LIMIT   = 8'd24;
  localparam logic [11:0] YRS_PER_CENTURY = 12'd100;
  localparam logic [11:0] LAST_YR_OF_CENTURY = 12'd99;
  localparam logic [3:0]  MON_JANUARY  = 4'd1;
  localparam logic [3:0]  MON_FEBRUARY = 4'd2;
  localparam logic [3:0]  MON_DECEMBER = 4'd12;

  // Datapath operations selected by the control word.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_WRAP_CENT,
    OP_WRAP_SEC,
    OP_WRAP_MIN,
    OP_WRAP_HR,
    OP_MONTH,
    OP_EMIT
  } op_t;

  // Sequencing of the step counter.
  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_LOOP,
    SEQ_JUMP
  } seq_t;

  typedef logic [2:0] step_t;

  typedef struct packed {
    op_t   op;
    seq_t  seq;
    step_t target;
  } ctrl_word_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    op_t op;
  } dp_ctrl_t;

  // Status from the datapath back to the sequencer.
  typedef struct packed {
    logic more;
  } dp_stat_t;

  // Microcode program: load, reduce the year to its century, carry the time of
  // day into the day count, walk the months, then present the result.
  function automatic ctrl_word_t ucode_rom(input step_t step);
    ctrl_word_t cw;
    unique case (step)
      3'd0:    cw = '{op: OP_LOAD,      seq: SEQ_NEXT, target: 3'd0};
      3'd1:    cw = '{op: OP_WRAP_CENT, seq: SEQ_LOOP, target: 3'd1};
      3'd2:    cw = '{op: OP_WRAP_SEC,  seq: SEQ_LOOP, target: 3'd2};
      3'd3:    cw = '{op: OP_WRAP_MIN,  seq: SEQ_LOOP, target: 3'd3};
      3'd4:    cw = '{op: OP_WRAP_HR,   seq: SEQ_LOOP, target: 3'd4};
      3'd5:    cw = '{op: OP_MONTH,     seq: SEQ_LOOP, target: 3'd5};
      default: cw = '{op: OP_EMIT,      seq: SEQ_JUMP, target: 3'd0};
    endcase
    return cw;
  endfunction

  // Length of a month in a common year.
  function automatic logic [4:0] month_len(input logic [3:0] month);
    logic [4:0] len;
    case (month)
      4'd2:                   len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:                len = 5'd31;
    endcase
    return len;
  endfunction

  // Remainder modulo seven of a small value (below 42).
  function automatic logic [2:0] mod7(input logic [5:0] v);
    logic [5:0] r;
    if (v >= 6'd35) begin
      r = v - 6'd35;
    end else if (v >= 6'd28) begin
      r = v - 6'd28;
    end else if (v >= 6'd21) begin
      r = v - 6'd21;
    end else if (v >= 6'd14) begin
      r = v - 6'd14;
    end else if (v >= 6'd7) begin
      r = v - 6'd7;
    end else begin
      r = v;
    end
    return r[2:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ecd_datapath.sv =====
// Datapath of the calendar date converter: time carries, century reduction and month walk.
`default_nettype none

module ecd_datapath import ecd_pkg::*; (
  input  wire logic              clk,
  input  wire dp_ctrl_t          ctrl,
  output dp_stat_t               stat,
  input  wire logic signed [15:0] elapsed_days,
  input  wire logic signed [7:0]  elapsed_hours,
  input  wire logic signed [7:0]  elapsed_minutes,
  input  wire logic signed [7:0]  elapsed_seconds,
  input  wire logic [11:0]       epoch_year,
  input  wire logic [2:0]        epoch_weekday,
  output logic [11:0]            year,
  output logic [3:0]             month,
  output logic [4:0]             day,
  output logic [2:0]             weekday,
  output logic [4:0]             hour,
  output logic [5:0]             minute,
  output logic [5:0]             second
);

  logic [6:0]  sec_r,   sec_nxt;
  logic [7:0]  min_r,   min_nxt;
  logic [7:0]  hr_r,    hr_nxt;
  logic [15:0] days_r,  days_nxt;
  logic [2:0]  wd_r,    wd_nxt;
  logic [12:0] year_r,  year_nxt;
  logic [11:0] yrem_r,  yrem_nxt;
  logic [1:0]  cent_r,  cent_nxt;
  logic [3:0]  month_r, month_nxt;
  logic [4:0]  day_r,   day_nxt;

  logic        leap;
  logic [4:0]  len;
  logic        finish;

  // Gregorian leap year from the year within its century and the century modulo four.
  assign leap = ((yrem_r[1:0] == 2'b00) && (yrem_r != 12'd0)) ||
                ((yrem_r == 12'd0) && (cent_r == 2'd0));

  // Length of the current month and whether the remaining days end inside it.
  assign len    = month_len(month_r) + {4'd0, (month_r == MON_FEBRUARY) && leap};
  assign finish = days_r < {11'd0, len};

  // Operation decode.
  always_comb begin
    sec_nxt   = sec_r;
    min_nxt   = min_r;
    hr_nxt    = hr_r;
    days_nxt  = days_r;
    wd_nxt    = wd_r;
    year_nxt  = year_r;
    yrem_nxt  = yrem_r;
    cent_nxt  = cent_r;
    month_nxt = month_r;
    day_nxt   = day_r;
    stat.more = 1'b0;
    unique case (ctrl.op)
      OP_LOAD: begin
        // Negative parts count as zero.
        sec_nxt   = elapsed_seconds[7] ? 7'd0 : elapsed_seconds[6:0];
        min_nxt   = elapsed_minutes[7] ? 8'd0 : {1'b0, elapsed_minutes[6:0]};
        hr_nxt    = elapsed_hours[7]   ? 8'd0 : {1'b0, elapsed_hours[6:0]};
        days_nxt  = elapsed_days[15]   ? 16'd0 : {1'b0, elapsed_days[14:0]};
        wd_nxt    = mod7({3'd0, epoch_weekday});
        year_nxt  = {1'b0, epoch_year};
        yrem_nxt  = epoch_year;
        cent_nxt  = 2'd0;
        month_nxt = MON_JANUARY;
        day_nxt   = 5'd1;
      end
      OP_WRAP_CENT: begin
        stat.more = yrem_r >= YRS_PER_CENTURY;
        if (stat.more) begin
          yrem_nxt = yrem_r - YRS_PER_CENTURY;
          cent_nxt = cent_r + 2'd1;
        end
      end
      OP_WRAP_SEC: begin
        stat.more = sec_r >= SEC_LIMIT;
        if (stat.more) begin
          sec_nxt = sec_r - SEC_LIMIT;
          min_nxt = min_r + 8'd1;
        end
      end
      OP_WRAP_MIN: begin
        stat.more = min_r >= MIN_LIMIT;
        if (stat.more) begin
          min_nxt = min_r - MIN_LIMIT;
          hr_nxt  = hr_r + 8'd1;
        end
      end
      OP_WRAP_HR: begin
        stat.more = hr_r >= HR_LIMIT;
        if (stat.more) begin
          hr_nxt   = hr_r - HR_LIMIT;
          days_nxt = days_r + 16'd1;
        end
      end
      OP_MONTH: begin
        stat.more = !finish;
        if (finish) begin
          // The remaining days fall inside this month.
          day_nxt  = 5'd1 + days_r[4:0];
          wd_nxt   = mod7({3'd0, wd_r} + {1'b0, days_r[4:0]});
          days_nxt = 16'd0;
        end else begin
          // Skip the whole month; the walk always stands on its first day.
          days_nxt = days_r - {11'd0, len};
          wd_nxt   = mod7({3'd0, wd_r} + {1'b0, len});
          if (month_r == MON_DECEMBER) begin
            month_nxt = MON_JANUARY;
            year_nxt  = year_r + 13'd1;
            if (yrem_r == LAST_YR_OF_CENTURY) begin
              yrem_nxt = 12'd0;
              cent_nxt = cent_r + 2'd1;
            end else begin
              yrem_nxt = yrem_r + 12'd1;
            end
          end else begin
            month_nxt = month_r + 4'd1;
          end
        end
      end
      OP_NOP, OP_EMIT: begin
        stat.more = 1'b0;
      end
      default: begin
        stat.more = 1'b0;
      end
    endcase
  end

  // Working registers carry payload only and need no reset.
  always_ff @(posedge clk) begin
    sec_r   <= sec_nxt;
    min_r   <= min_nxt;
    hr_r    <= hr_nxt;
    days_r  <= days_nxt;
    wd_r    <= wd_nxt;
    year_r  <= year_nxt;
    yrem_r  <= yrem_nxt;
    cent_r  <= cent_nxt;
    month_r <= month_nxt;
    day_r   <= day_nxt;
  end

  assign year    = year_r[11:0];
  assign month   = month_r;
  assign day     = day_r;
  assign weekday = wd_r;
  assign hour    = hr_r[4:0];
  assign minute  = min_r[5:0];
  assign second  = sec_r[5:0];

endmodule

`default_nettype wire

// ===== hw/rtl/elapsed_time_to_calendar_date.sv =====
// Top level of the elapsed time to calendar date converter with its microcode sequencer.
`default_nettype none

// A conversion starts when start is high while busy is low; busy then stays high
// until the result has been produced, and the result appears on the out_ ports for
// exactly one cycle, marked by out_valid, with no way for the receiver to stall it.
// The microcode sequencer steps through one load, a loop reducing the year to its
// century, loops for the second, minute and hour carries, a month walk with one step
// per whole month walked plus one for the final month, and one emit step; the month
// walk dominates for the largest day count. The result transfer takes place in the
// first cycle that busy is low, and a new command may be accepted in that same cycle.
// Configuration writes are always ready and must only be made while the block is idle.

module elapsed_time_to_calendar_date import ecd_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Command channel.
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic signed [15:0]    in_elapsed_days,
  input  wire logic signed [7:0]     in_elapsed_hours,
  input  wire logic signed [7:0]     in_elapsed_minutes,
  input  wire logic signed [7:0]     in_elapsed_seconds,
  // Result channel.
  output logic                       out_valid,
  output logic [11:0]                out_year,
  output logic [3:0]                 out_month,
  output logic [4:0]                 out_day,
  output logic [2:0]                 out_weekday,
  output logic [4:0]                 out_hour,
  output logic [5:0]                 out_minute,
  output logic [5:0]                 out_second,
  // Configuration write channel.
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic        busy_r,       busy_nxt;
  logic        out_valid_r,  out_valid_nxt;
  step_t       step_r,       step_nxt;
  logic [11:0] epoch_year_r;
  logic [2:0]  epoch_wd_r;

  logic        accept;
  logic        exec;
  ctrl_word_t  cw;
  dp_ctrl_t    dp_ctrl;
  dp_stat_t    dp_stat;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_year_r <= EPOCH_YEAR_RST;
      epoch_wd_r   <= EPOCH_WEEKDAY_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IDX_EPOCH_YEAR:    epoch_year_r <= cfg_data[11:0];
        CFG_IDX_EPOCH_WEEKDAY: epoch_wd_r   <= cfg_data[2:0];
        default:               epoch_year_r <= epoch_year_r;
      endcase
    end
  end

  // Sequencer: the load step runs in the cycle the command is accepted.
  assign accept = start && !busy_r;
  assign exec   = busy_r || accept;
  assign cw     = ucode_rom(step_r);

  always_comb begin
    dp_ctrl.op    = exec ? cw.op : OP_NOP;
    step_nxt      = step_r;
    busy_nxt      = busy_r;
    out_valid_nxt = 1'b0;
    if (accept) begin
      busy_nxt = 1'b1;
    end
    if (exec) begin
      unique case (cw.seq)
        SEQ_NEXT: step_nxt = step_r + 3'd1;
        SEQ_LOOP: step_nxt = dp_stat.more ? cw.target : step_r + 3'd1;
        SEQ_JUMP: step_nxt = cw.target;
        default:  step_nxt = cw.target;
      endcase
      if (cw.op == OP_EMIT) begin
        busy_nxt      = 1'b0;
        out_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;

  // Datapath; its registers hold the result while out_valid is high.
  ecd_datapath u_datapath (
    .clk             (clk),
    .ctrl            (dp_ctrl),
    .stat            (dp_stat),
    .elapsed_days    (in_elapsed_days),
    .elapsed_hours   (in_elapsed_hours),
    .elapsed_minutes (in_elapsed_minutes),
    .elapsed_seconds (in_elapsed_seconds),
    .epoch_year      (epoch_year_r),
    .epoch_weekday   (epoch_wd_r),
    .year            (out_year),
    .month           (out_month),
    .day             (out_day),
    .weekday         (out_weekday),
    .hour            (out_hour),
    .minute          (out_minute),
    .second          (out_second)
  );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the elapsed time to calendar date converter.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ecd_pkg::*;

  localparam int CLK_PERIOD       = 12;
  localparam int RESET_CYCLES     = 10;
  localparam int PHASES           = 9;
  localparam int RANDOM_PER_PHASE = 57;
  localparam int DRAIN_CYCLES     = 1200;
  localparam int CYCLE_LIMIT      = 3000000;

  // One elapsed time as presented to the command channel.
  typedef struct packed {
    logic [15:0] days;
    logic [7:0]  hours;
    logic [7:0]  minutes;
    logic [7:0]  seconds;
  } elapsed_t;

  // One calendar date and time of day as returned on the result channel.
  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [2:0]  weekday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } calendar_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] in_elapsed_days = '0;
  logic signed [7:0]  in_elapsed_hours = '0;
  logic signed [7:0]  in_elapsed_minutes = '0;
  logic signed [7:0]  in_elapsed_seconds = '0;
  logic        out_valid;
  logic [11:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day;
  logic [2:0]  out_weekday;
  logic [4:0]  out_hour;
  logic [5:0]  out_minute;
  logic [5:0]  out_second;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_IDX_EPOCH_YEAR;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Our own copy of the epoch registers, starting from their reset values.
  logic [11:0] epoch_year_reg = 12'd2000;
  logic [2:0]  epoch_weekday_reg = 3'd6;

  elapsed_t  elapsed_items[$];
  calendar_t expected_dates[$];
  elapsed_t  held_item;
  int        sender_idle_pct = 0;
  int        mismatch_count = 0;
  int        cycle_count = 0;

  elapsed_time_to_calendar_date u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_elapsed_days    (in_elapsed_days),
    .in_elapsed_hours   (in_elapsed_hours),
    .in_elapsed_minutes (in_elapsed_minutes),
    .in_elapsed_seconds (in_elapsed_seconds),
    .out_valid          (out_valid),
    .out_year           (out_year),
    .out_month          (out_month),
    .out_day            (out_day),
    .out_weekday        (out_weekday),
    .out_hour           (out_hour),
    .out_minute         (out_minute),
    .out_second         (out_second),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Works out the date and time of day reached from the current epoch.
  function automatic calendar_t convert_elapsed(input elapsed_t t);
    int unsigned d, h, m, s, mt, ht, days_left, yr, mon, dom, len;
    calendar_t r;
    // A negative part counts as zero.
    d = t.days[15] ? 0 : int'(t.days[14:0]);
    h = t.hours[7] ? 0 : int'(t.hours[6:0]);
    m = t.minutes[7] ? 0 : int'(t.minutes[6:0]);
    s = t.seconds[7] ? 0 : int'(t.seconds[6:0]);
    // Carry seconds into minutes, minutes into hours and hours into days.
    mt = m + s / 60;
    ht = h + mt / 60;
    days_left = d + ht / 24;
    r.second = 6'(s % 60);
    r.minute = 6'(mt % 60);
    r.hour = 5'(ht % 24);
    r.weekday = 3'((int'(epoch_weekday_reg) + days_left) % 7);
    // Walk the days forward a month at a time; leap years use the full year.
    yr = epoch_year_reg;
    mon = 1;
    dom = 1;
    while (days_left > 0) begin
      case (mon)
        2:           len = 28;
        4, 6, 9, 11: len = 30;
        default:     len = 31;
      endcase
      if (mon == 2 && ((yr % 4 == 0 && yr % 100 != 0) || yr % 400 == 0)) begin
        len++;
      end
      if (days_left > len - dom) begin
        days_left -= len - dom + 1;
        dom = 1;
        mon++;
        if (mon > 12) begin
          mon = 1;
          yr++;
        end
      end else begin
        dom += days_left;
        days_left = 0;
      end
    end
    r.year = 12'(yr);
    r.month = 4'(mon);
    r.day = 5'(dom);
    return r;
  endfunction

  // Command driver: presents queued items and records the expected date per transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_dates.push_back(convert_elapsed(held_item));
      end
      if (start && busy) begin
        // The item stays on the ports until the block takes it.
      end else if (elapsed_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        held_item = elapsed_items.pop_front();
        start <= 1'b1;
        in_elapsed_days <= held_item.days;
        in_elapsed_hours <= held_item.hours;
        in_elapsed_minutes <= held_item.minutes;
        in_elapsed_seconds <= held_item.seconds;
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Result monitor: each strobed result is compared with the oldest expected date.
  always @(posedge clk) begin
    calendar_t want;
    if (rst_n && out_valid) begin
      if (expected_dates.size() == 0) begin
        $error("result transfer with no conversion outstanding");
        mismatch_count++;
      end else begin
        want = expected_dates.pop_front();
        check_field("year", want.year, out_year);
        check_field("month", want.month, out_month);
        check_field("day", want.day, out_day);
        check_field("weekday", want.weekday, out_weekday);
        check_field("hour", want.hour, out_hour);
        check_field("minute", want.minute, out_minute);
        check_field("second", want.second, out_second);
      end
    end
  end

  // Watchdog against a hung block.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic queue_item(input int d, input int h, input int m, input int s);
    elapsed_t t;
    t.days = 16'(d);
    t.hours = 8'(h);
    t.minutes = 8'(m);
    t.seconds = 8'(s);
    elapsed_items.push_back(t);
  endtask

  // An hour, minute or second part: mostly any value, sometimes a carry edge.
  function automatic int random_part();
    int v;
    if ($urandom_range(99) < 20) begin
      case ($urandom_range(7))
        0:       v = 0;
        1:       v = 59;
        2:       v = 60;
        3:       v = 23;
        4:       v = 24;
        5:       v = 127;
        6:       v = -1;
        default: v = -128;
      endcase
    end else begin
      v = int'($urandom_range(255));
    end
    return v;
  endfunction

  // Most day counts are short so the month walk stays quick; a few are the longest.
  task automatic queue_random_item();
    int d, pick;
    pick = $urandom_range(99);
    if (pick < 45) begin
      d = $urandom_range(400);
    end else if (pick < 60) begin
      d = $urandom_range(4000);
    end else if (pick < 72) begin
      d = $urandom_range(32767);
    end else if (pick < 75) begin
      d = 32767;
    end else begin
      d = $urandom_range(65535);
    end
    queue_item(d, random_part(), random_part(), random_part());
  endtask

  // Wait until the sender has nothing left and every expected date has come back.
  task automatic wait_for_drain();
    while (elapsed_items.size() != 0 || start || busy || expected_dates.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    // The register transfer has happened at this edge.
    if (idx == CFG_IDX_EPOCH_YEAR) begin
      epoch_year_reg = data;
    end else begin
      epoch_weekday_reg = data[2:0];
    end
    cfg_valid <= 1'b0;
  endtask

  // Change the epoch only once the block has gone idle.
  task automatic set_epoch(input int unsigned year, input int unsigned wd);
    wait_for_drain();
    write_register(CFG_IDX_EPOCH_YEAR, CFG_DATA_W'(year));
    write_register(CFG_IDX_EPOCH_WEEKDAY, CFG_DATA_W'(wd));
    @(negedge clk);
  endtask

  initial begin
    int phase, year, wd, i;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    sender_idle_pct = 12;

    // Directed items against the reset epoch, a Saturday in 2000.
    queue_item(0, 0, 0, 0);
    queue_item(-32768, -128, -128, -128);
    queue_item(-1, -1, -1, -1);
    queue_item(0, 23, 59, 59);
    queue_item(0, 0, 0, 60);
    queue_item(0, 0, 59, 60);
    queue_item(0, 23, 59, 60);
    queue_item(0, 127, 127, 127);
    queue_item(30, 0, 0, 0);
    queue_item(31, 0, 0, 0);
    queue_item(59, 0, 0, 0);
    queue_item(60, 0, 0, 0);
    queue_item(365, 0, 0, 0);
    queue_item(366, 0, 0, 0);
    queue_item(32767, 127, 127, 127);
    queue_item(-5, 10, -3, 70);
    // A century year that is not a leap year, with the weekday register at seven.
    set_epoch(1900, 7);
    queue_item(59, 0, 0, 0);
    queue_item(0, 5, 6, 7);
    // The year runs past the width of the year field and wraps.
    set_epoch(4095, 0);
    queue_item(365, 0, 0, 0);
    queue_item(424, 0, 0, 0);
    // Year zero is divisible by 400 and so has a leap day.
    set_epoch(0, 3);
    queue_item(59, 0, 0, 0);
    queue_item(366, 1, 2, 3);

    // Random phases, each under its own epoch and sender idling.
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       begin year = 2000; wd = 6; end
        1:       begin year = 0;    wd = 0; end
        2:       begin year = 4095; wd = 7; end
        3:       begin year = 1900; wd = 1; end
        4:       begin year = 2100; wd = 2; end
        5:       begin year = 3000; wd = 5; end
        6:       begin year = 1999; wd = 4; end
        default: begin year = $urandom_range(4095); wd = $urandom_range(7); end
      endcase
      set_epoch(year, wd);
      sender_idle_pct = (phase < 3) ? 12 : (phase < 6) ? 87 : 0;
      for (i = 0; i < RANDOM_PER_PHASE; i++) begin
        queue_random_item();
      end
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
